/* rtl/core/usdmx_pkg.sv */
// shared types, constants and helpers for the udp socket table demultiplexer
package usdmx_pkg;

  localparam int ENTRIES    = 8;
  localparam int IFACE_BITS = 32;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SOCK_W     = 3;
  localparam int PORT_W     = 16;
  localparam int IP_W       = 32;
  localparam int IFN_W      = 5;
  localparam int CFG_IDX_W  = 2;

  localparam logic [PORT_W-1:0] UDP_HDR_BYTES = 16'd8;
  localparam logic [PORT_W-1:0] DYN_MIN_RST   = 16'd49152;
  localparam logic [PORT_W-1:0] DYN_MAX_RST   = 16'd65535;
  localparam logic [IDX_W-1:0]  LAST_IDX      = IDX_W'(ENTRIES - 1);

  typedef enum logic [2:0] {
    FN_OPEN    = 3'd0,
    FN_BIND    = 3'd1,
    FN_BIND_IF = 3'd2,
    FN_CLOSE   = 3'd3,
    FN_LOOKUP  = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_FREE  = 3'd1,
    ST_INVALID  = 3'd2,
    ST_SHORT    = 3'd3,
    ST_BAD_LEN  = 3'd4,
    ST_NO_MATCH = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DYN_MIN = 2'd0,
    CFG_DYN_MAX = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPEN_SCAN,
    S_SOCK_OP,
    S_LEN_SUB,
    S_LEN_EVAL,
    S_LOOKUP_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [PORT_W-1:0]     port;
    logic [IP_W-1:0]       ip;
    logic [IFACE_BITS-1:0] mask;
  } entry_t;

  typedef struct packed {
    logic [PORT_W-1:0]     port;
    logic [IP_W-1:0]       ip;
    logic [IFACE_BITS-1:0] rbit;
  } key_t;

  typedef struct packed {
    logic free;
    logic hit;
  } cmp_t;

  // one-hot interface bit, zero when the number lies beyond the mask
  function automatic logic [IFACE_BITS-1:0] iface_bit(input logic [IFN_W-1:0] n);
    logic [IFACE_BITS-1:0] b;
    b = '0;
    if (32'(n) < IFACE_BITS) begin
      b = IFACE_BITS'(1) << n;
    end
    return b;
  endfunction

endpackage

/* rtl/core/usdmx_match.sv */
// entry compare unit shared by the open scan, socket checks and lookup scan
module usdmx_match
  import usdmx_pkg::*;
(
  input  entry_t entry,
  input  key_t   key,
  output cmp_t   cmp
);

  logic port_eq;
  logic ip_ok;
  logic mask_ok;

  assign port_eq = (entry.port == key.port);
  assign ip_ok   = (entry.ip == '0) || (entry.ip == key.ip);
  assign mask_ok = (entry.mask == '0) || ((entry.mask & key.rbit) != '0);

  assign cmp.free = (entry.port == '0);
  assign cmp.hit  = !cmp.free && port_eq && ip_ok && mask_ok;

endmodule

/* rtl/core/udp_socket_table_demux_top.sv */
// udp socket table with open, bind, bind-interface, close and destination-port lookup
// each request runs to its result: open scans for the lowest free entry, bind/bind-interface/close
//   act on one entry, an unknown code goes straight to the result, lookup checks the lengths
//   and then scans, which compares one entry per cycle
// throughput: one request in flight, the next is taken the cycle after its result loads
// reset: synchronous rst frees all entries, restores port range and counter, clears out_valid
module udp_socket_table_demux_top
  import usdmx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           func,
  input  logic [3:0]           socket,
  input  logic [IP_W-1:0]      bind_ip,
  input  logic [PORT_W-1:0]    bind_port,
  input  logic [IFN_W-1:0]     bind_iface,
  input  logic [IFN_W-1:0]     rx_iface,
  input  logic [IP_W-1:0]      dst_ip,
  input  logic [PORT_W-1:0]    dst_port,
  input  logic [PORT_W-1:0]    udp_len,
  input  logic [PORT_W-1:0]    ip_total_len,
  input  logic [PORT_W-1:0]    ip_hdr_len,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           status,
  output logic [SOCK_W-1:0]    socket_out,
  output logic [PORT_W-1:0]    port_out,
  output logic [PORT_W-1:0]    payload_len,
  // register write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PORT_W-1:0]    cfg_data
);

  state_t state, state_next;

  // socket table: port array is cleared by reset, address and mask are not
  logic [PORT_W-1:0]     entry_port [ENTRIES];
  logic [IP_W-1:0]       entry_ip [ENTRIES];
  logic [IFACE_BITS-1:0] entry_iface_mask [ENTRIES];

  // dynamic port range and counter
  logic [PORT_W-1:0] dyn_port_min;
  logic [PORT_W-1:0] dyn_port_max;
  logic [PORT_W-1:0] next_dyn_port, next_dyn_port_next;
  logic [PORT_W:0]   dyn_inc;

  // captured request
  logic [2:0]        func_q;
  logic [3:0]        sock_q;
  logic [IP_W-1:0]   bind_ip_q;
  logic [PORT_W-1:0] bind_port_q;
  logic [IFN_W-1:0]  bind_iface_q;
  logic [IFN_W-1:0]  rx_iface_q;
  logic [IP_W-1:0]   dst_ip_q;
  logic [PORT_W-1:0] dst_port_q;
  logic [PORT_W-1:0] udp_len_q;
  logic [PORT_W-1:0] tot_len_q;
  logic [PORT_W-1:0] hdr_len_q;

  // length check intermediate
  logic [PORT_W-1:0] rest;
  logic              hdr_over;

  // scan position and working result
  logic [IDX_W-1:0]  scan_idx, scan_idx_next;
  status_t           res_status, res_status_next;
  logic [SOCK_W-1:0] res_sock, res_sock_next;
  logic [PORT_W-1:0] res_port, res_port_next;
  logic [PORT_W-1:0] res_plen, res_plen_next;

  // table access
  logic [IDX_W-1:0]      rd_idx;
  logic [IDX_W-1:0]      sock_idx;
  logic                  sock_in_range;
  entry_t                rd_entry;
  key_t                  key;
  cmp_t                  cmp;
  logic                  wr_port_en;
  logic                  wr_ip_en;
  logic                  wr_mask_en;
  logic [IDX_W-1:0]      wr_idx;
  logic [PORT_W-1:0]     wr_port;
  logic [IP_W-1:0]       wr_ip;
  logic [IFACE_BITS-1:0] wr_mask;

  logic in_take;
  logic out_load;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);

  // socket index of bind, bind-interface and close
  assign sock_in_range = (32'(sock_q) < ENTRIES);
  assign sock_idx      = IDX_W'(sock_q);

  // single read address: the socket for socket ops, the scan index otherwise
  assign rd_idx        = (state == S_SOCK_OP) ? sock_idx : scan_idx;
  assign rd_entry.port = entry_port[rd_idx];
  assign rd_entry.ip   = entry_ip[rd_idx];
  assign rd_entry.mask = entry_iface_mask[rd_idx];

  assign key.port = dst_port_q;
  assign key.ip   = dst_ip_q;
  assign key.rbit = iface_bit(rx_iface_q);

  usdmx_match u_match (
    .entry (rd_entry),
    .key   (key),
    .cmp   (cmp)
  );

  // dynamic port advance, wraps to the minimum once past the maximum
  assign dyn_inc = {1'b0, next_dyn_port} + {{PORT_W{1'b0}}, 1'b1};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dyn_port_min <= DYN_MIN_RST;
      dyn_port_max <= DYN_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DYN_MIN: dyn_port_min <= cfg_data;
        CFG_DYN_MAX: dyn_port_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      next_dyn_port <= DYN_MIN_RST;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      next_dyn_port <= next_dyn_port_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    scan_idx   <= scan_idx_next;
    res_status <= res_status_next;
    res_sock   <= res_sock_next;
    res_port   <= res_port_next;
    res_plen   <= res_plen_next;
    rest       <= tot_len_q - hdr_len_q;
    hdr_over   <= (hdr_len_q > tot_len_q);
    if (in_take) begin
      func_q       <= func;
      sock_q       <= socket;
      bind_ip_q    <= bind_ip;
      bind_port_q  <= bind_port;
      bind_iface_q <= bind_iface;
      rx_iface_q   <= rx_iface;
      dst_ip_q     <= dst_ip;
      dst_port_q   <= dst_port;
      udp_len_q    <= udp_len;
      tot_len_q    <= ip_total_len;
      hdr_len_q    <= ip_hdr_len;
    end
    if (out_load) begin
      status      <= res_status;
      socket_out  <= res_sock;
      port_out    <= res_port;
      payload_len <= res_plen;
    end
  end

  // entry ports: cleared by reset so every entry starts free
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        entry_port[i] <= '0;
      end
    end else if (wr_port_en) begin
      entry_port[wr_idx] <= wr_port;
    end
  end

  // entry address and interface mask
  always_ff @(posedge clk) begin
    if (wr_ip_en) begin
      entry_ip[wr_idx] <= wr_ip;
    end
    if (wr_mask_en) begin
      entry_iface_mask[wr_idx] <= wr_mask;
    end
  end

  // sequencer
  always_comb begin
    state_next         = state;
    scan_idx_next      = scan_idx;
    res_status_next    = res_status;
    res_sock_next      = res_sock;
    res_port_next      = res_port;
    res_plen_next      = res_plen;
    next_dyn_port_next = next_dyn_port;
    wr_port_en         = 1'b0;
    wr_ip_en           = 1'b0;
    wr_mask_en         = 1'b0;
    wr_idx             = rd_idx;
    wr_port            = '0;
    wr_ip              = '0;
    wr_mask            = '0;

    case (state)
      S_IDLE: begin
        scan_idx_next   = '0;
        res_status_next = ST_OK;
        res_sock_next   = '0;
        res_port_next   = '0;
        res_plen_next   = '0;
        if (in_valid) begin
          case (func)
            FN_OPEN:                        state_next = S_OPEN_SCAN;
            FN_BIND, FN_BIND_IF, FN_CLOSE:  state_next = S_SOCK_OP;
            FN_LOOKUP:                      state_next = S_LEN_SUB;
            default:                        state_next = S_DONE;
          endcase
        end
      end

      // find the lowest free entry and claim it with the next dynamic port
      S_OPEN_SCAN: begin
        if (cmp.free) begin
          wr_port_en    = 1'b1;
          wr_ip_en      = 1'b1;
          wr_mask_en    = 1'b1;
          wr_port       = next_dyn_port;
          res_sock_next = SOCK_W'(scan_idx);
          res_port_next = next_dyn_port;
          next_dyn_port_next = (dyn_inc > {1'b0, dyn_port_max}) ?
                               dyn_port_min : dyn_inc[PORT_W-1:0];
          state_next    = S_DONE;
        end else if (scan_idx == LAST_IDX) begin
          res_status_next = ST_NO_FREE;
          state_next      = S_DONE;
        end else begin
          scan_idx_next = scan_idx + IDX_W'(1);
        end
      end

      // bind, bind-interface and close on an open entry
      S_SOCK_OP: begin
        state_next = S_DONE;
        if (!sock_in_range || cmp.free) begin
          res_status_next = ST_INVALID;
        end else begin
          case (func_q)
            FN_BIND: begin
              wr_port_en = 1'b1;
              wr_ip_en   = 1'b1;
              wr_port    = bind_port_q;
              wr_ip      = bind_ip_q;
            end
            FN_BIND_IF: begin
              wr_mask_en = 1'b1;
              wr_mask    = rd_entry.mask | iface_bit(bind_iface_q);
            end
            FN_CLOSE: begin
              wr_port_en = 1'b1;
              wr_port    = '0;
            end
            default: ;
          endcase
        end
      end

      // bytes after the ip header are formed in this cycle
      S_LEN_SUB: begin
        state_next = S_LEN_EVAL;
      end

      S_LEN_EVAL: begin
        if (hdr_over || (rest < UDP_HDR_BYTES)) begin
          res_status_next = ST_SHORT;
          state_next      = S_DONE;
        end else if ((udp_len_q < UDP_HDR_BYTES) || (udp_len_q > rest)) begin
          res_status_next = ST_BAD_LEN;
          state_next      = S_DONE;
        end else begin
          scan_idx_next = '0;
          state_next    = S_LOOKUP_SCAN;
        end
      end

      // first entry matching port, address and interface wins
      S_LOOKUP_SCAN: begin
        if (cmp.hit) begin
          res_status_next = ST_OK;
          res_sock_next   = SOCK_W'(scan_idx);
          res_plen_next   = udp_len_q - UDP_HDR_BYTES;
          state_next      = S_DONE;
        end else if (scan_idx == LAST_IDX) begin
          res_status_next = ST_NO_MATCH;
          state_next      = S_DONE;
        end else begin
          scan_idx_next = scan_idx + IDX_W'(1);
        end
      end

      // hand the result to the output register once it has room
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // a taken request always leaves idle
  assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state != S_IDLE))
    else $error("request taken but sequencer stayed idle");

  // a new result only appears when the sequencer finishes a request
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result appeared without a finished request");

  // a free entry found by open ends the scan with an ok result
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OPEN_SCAN && cmp.free) |=> (state == S_DONE && res_status == ST_OK))
    else $error("open did not claim the free entry");

  // table writes only happen while a socket op or open is in progress
  assert property (@(posedge clk) disable iff (rst)
    (wr_port_en || wr_ip_en || wr_mask_en) |->
      (state == S_OPEN_SCAN || state == S_SOCK_OP))
    else $error("table written outside open or socket op");

endmodule
